// ----- design/bhd_pkg.sv -----
`default_nettype none

package bhd_pkg;

  // field widths on the stream ports
  localparam int CNT_W       = 6;            // n_particles, lz_max
  localparam int TOT_W       = 12;           // total_lz
  localparam int DIM_W       = 63;           // dimension
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;
  localparam int LIM_W       = CNT_W + 1;    // holds a bound up to 64
  localparam int NM_W        = 2 * CNT_W;    // N*M from two 6-bit fields
  localparam int SUM_W       = NM_W + 2;     // total_lz + N*M, two's complement
  localparam int COEF_W      = 64;           // coefficients wrap modulo 2^64

  localparam int DEF_MAX_PARTICLES = 32;
  localparam int DEF_MAX_LZ        = 32;

  // microprogram
  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] S_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] S_CHECK   = 4'd1;
  localparam logic [PC_W-1:0] S_BRANCH  = 4'd2;
  localparam logic [PC_W-1:0] S_CLEAR   = 4'd3;
  localparam logic [PC_W-1:0] S_PASS    = 4'd4;
  localparam logic [PC_W-1:0] S_SETUP_P = 4'd5;
  localparam logic [PC_W-1:0] S_SWEEP_P = 4'd6;
  localparam logic [PC_W-1:0] S_SETUP_D = 4'd7;
  localparam logic [PC_W-1:0] S_SWEEP_D = 4'd8;
  localparam logic [PC_W-1:0] S_LOOP    = 4'd9;
  localparam logic [PC_W-1:0] S_READ    = 4'd10;
  localparam logic [PC_W-1:0] S_CAPTURE = 4'd11;
  localparam logic [PC_W-1:0] S_LOAD    = 4'd12;

  typedef enum logic [2:0] {
    X_HOLD   = 3'd0,
    X_ZERO   = 3'd1,
    X_LD_I   = 3'd2,
    X_LD_TOP = 3'd3,
    X_INC    = 3'd4,
    X_DEC    = 3'd5
  } x_op_t;

  typedef enum logic [1:0] {
    I_HOLD = 2'd0,
    I_CLR  = 2'd1,
    I_INC  = 2'd2
  } i_op_t;

  typedef enum logic [2:0] {
    M_NONE  = 3'd0,
    M_CLEAR = 3'd1,
    M_ADD   = 3'd2,
    M_SUB   = 3'd3,
    M_READ  = 3'd4
  } mem_op_t;

  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_NO_IN    = 4'd1,
    C_BAD      = 4'd2,
    C_X_LT_TOP = 4'd3,
    C_X_GT_W   = 4'd4,
    C_P_EMPTY  = 4'd5,
    C_D_EMPTY  = 4'd6,
    C_I_LT_N   = 4'd7,
    C_OUT_BUSY = 4'd8
  } cond_t;

  typedef struct packed {
    logic            in_rdy;
    logic            chk;
    logic            cap;
    logic            load;
    logic            done;
    x_op_t           x_op;
    i_op_t           i_op;
    mem_op_t         mem_op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic bad;
    logic x_lt_top;
    logic x_gt_w;
    logic p_empty;
    logic d_empty;
    logic i_lt_n;
    logic out_busy;
  } status_t;

  // control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c        = '0;
    c.x_op   = X_HOLD;
    c.i_op   = I_HOLD;
    c.mem_op = M_NONE;
    c.cond   = C_NEVER;
    c.target = S_IDLE;
    case (pc)
      S_IDLE: begin
        c.in_rdy = 1'b1;
        c.x_op   = X_ZERO;
        c.i_op   = I_CLR;
        c.cond   = C_NO_IN;
        c.target = S_IDLE;
      end
      S_CHECK: begin
        c.chk = 1'b1;
      end
      S_BRANCH: begin
        c.cond   = C_BAD;
        c.target = S_LOAD;
      end
      S_CLEAR: begin
        c.mem_op = M_CLEAR;
        c.x_op   = X_INC;
        c.cond   = C_X_LT_TOP;
        c.target = S_CLEAR;
      end
      S_PASS: begin
        c.i_op = I_INC;
      end
      S_SETUP_P: begin
        c.x_op   = X_LD_I;
        c.cond   = C_P_EMPTY;
        c.target = S_SETUP_D;
      end
      S_SWEEP_P: begin
        c.mem_op = M_ADD;
        c.x_op   = X_INC;
        c.cond   = C_X_LT_TOP;
        c.target = S_SWEEP_P;
      end
      S_SETUP_D: begin
        c.x_op   = X_LD_TOP;
        c.cond   = C_D_EMPTY;
        c.target = S_LOOP;
      end
      S_SWEEP_D: begin
        c.mem_op = M_SUB;
        c.x_op   = X_DEC;
        c.cond   = C_X_GT_W;
        c.target = S_SWEEP_D;
      end
      S_LOOP: begin
        c.cond   = C_I_LT_N;
        c.target = S_PASS;
      end
      S_READ: begin
        c.mem_op = M_READ;
      end
      S_CAPTURE: begin
        c.cap = 1'b1;
      end
      S_LOAD: begin
        c.load   = 1'b1;
        c.done   = 1'b1;
        c.cond   = C_OUT_BUSY;
        c.target = S_LOAD;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/boson_hilbert_dimension.sv -----
// Boson state counter: each in_ beat carries N (particles), M (twice the
// maximum momentum) and twice the total momentum; the block returns on out_
// one beat holding the number of multisets of N levels in 0..M summing to
// T = floor((total + N*M)/2), i.e. the q^T coefficient of the Gaussian
// binomial [N+M choose N], or zero when N is 0, T is out of 0..N*M, or N, M
// exceed MAX_PARTICLES, MAX_LZ. One item at a time. With P = N*M, the run
// time of an item is set by the single write port of the coefficient RAM:
// one coefficient is updated per cycle, the table of P+1 entries is cleared
// for each item, then each of the N passes runs one rising add sweep and
// one falling subtract sweep (an empty sweep is skipped). An item whose
// answer is zero by the range rules skips the table work. A microcoded
// sequencer steps through a thirteen-word control store; the result sits
// in an output register, so the next item is taken while a result still
// waits.
`default_nettype none

module boson_hilbert_dimension #(
  parameter int MAX_PARTICLES = bhd_pkg::DEF_MAX_PARTICLES,
  parameter int MAX_LZ        = bhd_pkg::DEF_MAX_LZ
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // n_particles [5:0], lz_max [11:6], total_lz [23:12]
  input  wire logic [bhd_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // dimension [62:0], zero pad [63]
  output logic      [bhd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  bhd_pkg::ctrl_t   ctrl;
  bhd_pkg::status_t stat;

  // only the idle step of the microprogram takes a beat
  assign in_tready = ctrl.in_rdy;

  bhd_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // table sweeps, forwarding across the RAM read latency, output register
  bhd_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_LZ        (MAX_LZ)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_tvalid && in_tready),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- design/bhd_ram.sv -----
`default_nettype none

module bhd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra0,
  input  wire logic [$clog2(DEPTH)-1:0] ra1,
  output logic      [WIDTH-1:0]         rd0,
  output logic      [WIDTH-1:0]         rd1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

`default_nettype wire

// ----- design/bhd_sequencer.sv -----
`default_nettype none

module bhd_sequencer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire bhd_pkg::status_t stat,
  output bhd_pkg::ctrl_t       ctrl
);

  logic [bhd_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     take;

  assign ctrl = bhd_pkg::ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      bhd_pkg::C_NEVER:    take = 1'b0;
      bhd_pkg::C_NO_IN:    take = !in_tvalid;
      bhd_pkg::C_BAD:      take = stat.bad;
      bhd_pkg::C_X_LT_TOP: take = stat.x_lt_top;
      bhd_pkg::C_X_GT_W:   take = stat.x_gt_w;
      bhd_pkg::C_P_EMPTY:  take = stat.p_empty;
      bhd_pkg::C_D_EMPTY:  take = stat.d_empty;
      bhd_pkg::C_I_LT_N:   take = stat.i_lt_n;
      bhd_pkg::C_OUT_BUSY: take = stat.out_busy;
      default:             take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.done) begin
      pc_nxt = bhd_pkg::S_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bhd_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/bhd_datapath.sv -----
`default_nettype none

module bhd_datapath #(
  parameter int MAX_PARTICLES = bhd_pkg::DEF_MAX_PARTICLES,
  parameter int MAX_LZ        = bhd_pkg::DEF_MAX_LZ
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_accept,
  input  wire logic [bhd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              out_tready,
  input  wire bhd_pkg::ctrl_t                    ctrl,
  output bhd_pkg::status_t                       stat,
  output logic                                   out_tvalid,
  output logic      [bhd_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int DEPTH = MAX_PARTICLES * MAX_LZ + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_PARTICLES * MAX_LZ + MAX_PARTICLES + MAX_LZ + 1);
  localparam int IW    = $clog2(MAX_PARTICLES + 1);
  localparam int CW    = bhd_pkg::CNT_W;
  localparam int TW    = bhd_pkg::TOT_W;
  localparam int SW    = bhd_pkg::SUM_W;
  localparam int NW    = bhd_pkg::NM_W;
  localparam int LW    = bhd_pkg::LIM_W;
  localparam int DW    = bhd_pkg::COEF_W;
  localparam int OW    = bhd_pkg::DIM_W;

  // latched item
  logic [CW-1:0] n_r, m_r;
  logic [TW-1:0] tot_r;

  // item decode
  logic          ok_r;
  logic [KW-1:0] top_r, t_r;

  // loop registers
  logic [KW-1:0] x_r, x_nxt;
  logic [IW-1:0] i_r, i_nxt;

  // write-back stage of the sweep
  logic          pend_r, pend_sub_r;
  logic [AW-1:0] pend_addr_r;
  logic          fwd_a_r, fwd_b_r;
  logic [DW-1:0] fwd_d_r;

  logic [OW-1:0] dim_r;
  logic          out_valid_r;
  logic [OW-1:0] out_dim_r;

  logic [NW-1:0] nm;
  logic [SW-1:0] sum;
  logic          ok;
  logic [KW-1:0] w, rb_k;
  logic [AW-1:0] ra, rb, wa;
  logic [DW-1:0] rd_a, rd_b, a_val, b_val, wd;
  logic          we, issue, out_busy;

  // decode: T = (total + N*M) >> 1, valid only inside 0..N*M
  always_comb begin
    nm  = n_r * m_r;
    sum = {{(SW - TW){tot_r[TW-1]}}, tot_r} + SW'(nm);
    ok  = (n_r != '0) && (LW'(n_r) <= LW'(MAX_PARTICLES)) && (LW'(m_r) <= LW'(MAX_LZ)) &&
          !sum[SW-1] && (sum[SW-1:1] <= (SW - 1)'(nm));
  end

  assign w        = KW'(m_r) + KW'(i_r);
  assign out_busy = out_valid_r && !out_tready;

  assign stat.bad      = !ok_r;
  assign stat.x_lt_top = x_r < top_r;
  assign stat.x_gt_w   = x_r > w;
  assign stat.p_empty  = KW'(i_r) > top_r;
  assign stat.d_empty  = w > top_r;
  assign stat.i_lt_n   = i_r < IW'(n_r);
  assign stat.out_busy = out_busy;

  always_comb begin
    case (ctrl.x_op)
      bhd_pkg::X_HOLD:   x_nxt = x_r;
      bhd_pkg::X_ZERO:   x_nxt = '0;
      bhd_pkg::X_LD_I:   x_nxt = KW'(i_r);
      bhd_pkg::X_LD_TOP: x_nxt = top_r;
      bhd_pkg::X_INC:    x_nxt = x_r + 1'b1;
      bhd_pkg::X_DEC:    x_nxt = x_r - 1'b1;
      default:           x_nxt = x_r;
    endcase
  end

  always_comb begin
    case (ctrl.i_op)
      bhd_pkg::I_HOLD: i_nxt = i_r;
      bhd_pkg::I_CLR:  i_nxt = '0;
      bhd_pkg::I_INC:  i_nxt = i_r + 1'b1;
      default:         i_nxt = i_r;
    endcase
  end

  // read addresses: the entry itself and the one it takes a term from
  always_comb begin
    issue = (ctrl.mem_op == bhd_pkg::M_ADD) || (ctrl.mem_op == bhd_pkg::M_SUB);
    ra    = (ctrl.mem_op == bhd_pkg::M_READ) ? t_r[AW-1:0] : x_r[AW-1:0];
    case (ctrl.mem_op)
      bhd_pkg::M_ADD: rb_k = x_r - KW'(i_r);
      bhd_pkg::M_SUB: rb_k = x_r - w;
      default:        rb_k = x_r;
    endcase
    rb = rb_k[AW-1:0];
  end

  // write port: pending sweep result has priority over the clearing pass
  always_comb begin
    a_val = fwd_a_r ? fwd_d_r : rd_a;
    b_val = fwd_b_r ? fwd_d_r : rd_b;
    if (pend_r) begin
      we = 1'b1;
      wa = pend_addr_r;
      wd = pend_sub_r ? (a_val - b_val) : (a_val + b_val);
    end else begin
      we = (ctrl.mem_op == bhd_pkg::M_CLEAR);
      wa = x_r[AW-1:0];
      wd = DW'(x_r == '0);
    end
  end

  bhd_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra0 (ra),
    .ra1 (rb),
    .rd0 (rd_a),
    .rd1 (rd_b)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      n_r   <= in_tdata[CW-1:0];
      m_r   <= in_tdata[2*CW-1:CW];
      tot_r <= in_tdata[2*CW+TW-1:2*CW];
    end
    if (ctrl.chk) begin
      ok_r  <= ok;
      top_r <= KW'(nm);
      t_r   <= KW'(sum[SW-1:1]);
    end
    x_r         <= x_nxt;
    i_r         <= i_nxt;
    pend_sub_r  <= (ctrl.mem_op == bhd_pkg::M_SUB);
    pend_addr_r <= x_r[AW-1:0];
    fwd_a_r     <= we && (wa == ra);
    fwd_b_r     <= we && (wa == rb);
    fwd_d_r     <= wd;
    if (ctrl.cap) begin
      dim_r <= a_val[OW-1:0];
    end
    if (ctrl.load && !out_busy) begin
      out_dim_r <= ok_r ? dim_r : '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= issue;
      if (ctrl.load && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_dim_r};

endmodule

`default_nettype wire

// ----- design/bhd_checker.sv -----
`default_nettype none

module bhd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [bhd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // an accepted beat keeps the input closed for at least the decode steps
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##1 !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input reopened too early");

  // a new result is loaded only from a busy step
  a_rise_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

  // the count is 63 bits, pad bit stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[bhd_pkg::OUT_TDATA_W-1])
    else $error("pad bit set on result");

endmodule

bind boson_hilbert_dimension bhd_checker u_bhd_checker (.*);

`default_nettype wire
